// ----- rtl/core/sax_enc_pkg.sv -----
// ---------------------------------------------------------------------------
// sax_enc_pkg: shared types and constants of the SAX word encoder
// Field widths, register indexes and the symbol alphabet.
// ---------------------------------------------------------------------------
package sax_enc_pkg;

    // Fixed field widths
    localparam int SUM_W     = 28;   // running segment sum, signed
    localparam int CNT_W     = 10;   // samples already in the segment
    localparam int LEN_W     = 11;   // segment_length register
    localparam int SYM_W     = 2;    // one symbol
    localparam int WORD_W    = 5;    // base-3 word index
    localparam int SEG_W     = 2;    // segment number
    localparam int CFG_IDX_W = 3;    // configuration index
    localparam int CFG_DAT_W = 16;   // configuration data
    localparam int M_DATA_W  = 16;   // three symbols and the word, byte padded

    localparam logic [LEN_W-1:0] SEG_LEN_MAX = LEN_W'(1024);
    localparam logic [SEG_W-1:0] LAST_SEG    = SEG_W'(2);
    localparam int               ALPHABET    = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEAN     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INV_STD  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CUT_LOW  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CUT_HIGH = CFG_IDX_W'(4);

    typedef logic [SYM_W-1:0] t_sym;

endpackage

// ----- rtl/core/sax_word_encoder.sv -----
// ---------------------------------------------------------------------------
// sax_word_encoder: three-symbol SAX word encoder
// Sums each segment of a window relative to the baseline mean, classifies
// the normalized segment mean against two cutpoints and emits a 3-symbol word.
// ---------------------------------------------------------------------------
//  channel   | direction | transaction                                | fields
//  s (input) | in        | i_s_tvalid & o_s_tready                    | sample, window_start
//  m (result)| out       | o_m_tvalid & i_m_tready                    | symbols, word_index
//  cfg       | in        | i_cfg_valid & o_cfg_ready                  | index, data
//
//  One sample per cycle unless stalled; the segment sum runs in the accept
//  cycle, the three multiplies of the classification take one more stage,
//  the compare a third, which loads the word into the output register.
//  Reset (synchronous, i_rst_n low) clears the sum, counters and pipe valids
//  and loads the register defaults. The input stalls only while a finished
//  word waits in the output register and another one is ready behind it.
// ---------------------------------------------------------------------------
module sax_word_encoder #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // sample stream
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         i_s_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                                     i_s_tuser,  // [0] window_start
    // word stream
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    output logic [sax_enc_pkg::M_DATA_W-1:0]         o_m_tdata,  // [1:0] symbol_first,
                                                                 // [3:2] symbol_second,
                                                                 // [5:4] symbol_third,
                                                                 // [10:6] word_index
    // configuration writes
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [sax_enc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sax_enc_pkg::CFG_DAT_W-1:0]        i_cfg_data
);

    localparam int SUM_W  = sax_enc_pkg::SUM_W;
    localparam int LEN_W  = sax_enc_pkg::LEN_W;
    localparam int CNT_W  = sax_enc_pkg::CNT_W;
    localparam int SEG_W  = sax_enc_pkg::SEG_W;
    localparam int DIFF_W = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
    localparam int ACC_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + 17;          // sum x unsigned 16-bit scale
    localparam int LHS_W  = PROD_W + 4;          // times 16
    localparam int CUT_W  = 16 + LEN_W + 1;      // cut x length

    localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'((64'sd1 <<< (SUM_W-1)) - 1);
    localparam logic signed [ACC_W-1:0] SUM_MIN = -ACC_W'(64'sd1 <<< (SUM_W-1));

    // Configuration registers
    logic        [LEN_W-1:0] r_seg_len;
    logic signed [15:0]      r_mean;
    logic        [15:0]      r_inv_std;
    logic signed [15:0]      r_cut_low;
    logic        [14:0]      r_cut_high;

    // Accumulator state
    logic signed [SUM_W-1:0] r_sum,  n_sum;
    logic        [CNT_W-1:0] r_cnt,  n_cnt;
    logic        [SEG_W-1:0] r_seg,  n_seg;

    // Multiply stage
    logic                    r_b_valid;
    logic signed [SUM_W-1:0] r_b_sum,  n_b_sum;
    logic        [LEN_W-1:0] r_b_len;
    logic        [SEG_W-1:0] r_b_seg;

    // Compare stage
    logic                     r_c_valid;
    logic signed [PROD_W-1:0] r_c_prod;
    logic signed [CUT_W-1:0]  r_c_low;
    logic signed [CUT_W-1:0]  r_c_high;
    logic        [SEG_W-1:0]  r_c_seg;

    // Held symbols and output register
    sax_enc_pkg::t_sym        r_held0, r_held1;
    logic                     r_out_valid;
    sax_enc_pkg::t_sym        r_out_s0, r_out_s1, r_out_s2;
    logic [sax_enc_pkg::WORD_W-1:0] r_out_word;

    logic                    en;
    logic                    s_acc;
    logic [LEN_W-1:0]        eff_len;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_sat;
    logic signed [SUM_W-1:0] base_sum;
    logic        [CNT_W-1:0] base_cnt;
    logic        [SEG_W-1:0] base_seg;
    logic                    seg_end;
    logic signed [LHS_W-1:0] lhs;
    sax_enc_pkg::t_sym       sym;
    logic                    c_last;

    // Stall the whole pipe only when a word would collide with a waiting one
    assign c_last     = r_c_valid && (r_c_seg == sax_enc_pkg::LAST_SEG);
    assign en         = !(r_out_valid && !i_m_tready && c_last);
    assign o_s_tready = en;
    assign s_acc      = i_s_tvalid && en;
    assign o_cfg_ready = 1'b1;

    // Clamp the segment length to 1..1024
    always_comb begin
        if (r_seg_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_seg_len > sax_enc_pkg::SEG_LEN_MAX) begin
            eff_len = sax_enc_pkg::SEG_LEN_MAX;
        end else begin
            eff_len = r_seg_len;
        end
    end

    // Accumulate the sample with saturation and detect segment end
    always_comb begin
        base_sum = i_s_tuser ? '0 : r_sum;
        base_cnt = i_s_tuser ? '0 : r_cnt;
        base_seg = i_s_tuser ? '0 : r_seg;
        diff     = DIFF_W'($signed(i_s_tdata[SAMPLE_BITS-1:0])) - DIFF_W'(r_mean);
        acc      = ACC_W'(base_sum) + ACC_W'(diff);
        if (acc > SUM_MAX) begin
            acc_sat = SUM_MAX;
        end else if (acc < SUM_MIN) begin
            acc_sat = SUM_MIN;
        end else begin
            acc_sat = acc;
        end
        n_b_sum = SUM_W'(acc_sat);
        seg_end = !((LEN_W'(base_cnt) + LEN_W'(1)) < eff_len);
        if (seg_end) begin
            n_sum = '0;
            n_cnt = '0;
            n_seg = (base_seg == sax_enc_pkg::LAST_SEG) ? '0 : base_seg + SEG_W'(1);
        end else begin
            n_sum = n_b_sum;
            n_cnt = base_cnt + CNT_W'(1);
            n_seg = base_seg;
        end
    end

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len  <= LEN_W'(16);
            r_mean     <= '0;
            r_inv_std  <= 16'd256;
            r_cut_low  <= -16'sd1761;
            r_cut_high <= 15'd1761;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sax_enc_pkg::REG_SEG_LEN:  r_seg_len  <= i_cfg_data[LEN_W-1:0];
                sax_enc_pkg::REG_MEAN:     r_mean     <= $signed(i_cfg_data);
                sax_enc_pkg::REG_INV_STD:  r_inv_std  <= i_cfg_data;
                sax_enc_pkg::REG_CUT_LOW:  r_cut_low  <= $signed(i_cfg_data);
                sax_enc_pkg::REG_CUT_HIGH: r_cut_high <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Control state: accumulator, counters, pipe valids and held symbols
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_seg       <= '0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_held0     <= '0;
            r_held1     <= '0;
        end else begin
            if (s_acc) begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
                r_seg <= n_seg;
            end
            if (en) begin
                r_b_valid <= s_acc && seg_end;
                r_c_valid <= r_b_valid;
                if (r_c_valid && !c_last) begin
                    if (r_c_seg[0]) begin
                        r_held1 <= sym;
                    end else begin
                        r_held0 <= sym;
                    end
                end
            end
            // Load a finished word, drop one that was taken
            if (en && c_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Classification: count the cutpoints reached
    assign lhs = {r_c_prod, 4'b0000};
    always_comb begin
        sym = '0;
        if (lhs >= LHS_W'(r_c_low)) begin
            sym = sym + 2'd1;
        end
        if (lhs >= LHS_W'(r_c_high)) begin
            sym = sym + 2'd1;
        end
    end

    // Payload pipe: segment sum, products, output word
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sum  <= n_b_sum;
            r_b_len  <= eff_len;
            r_b_seg  <= base_seg;
            r_c_prod <= r_b_sum * $signed({1'b0, r_inv_std});
            r_c_low  <= r_cut_low * $signed({1'b0, r_b_len});
            r_c_high <= $signed({1'b0, r_cut_high}) * $signed({1'b0, r_b_len});
            r_c_seg  <= r_b_seg;
            if (c_last) begin
                r_out_s0   <= r_held0;
                r_out_s1   <= r_held1;
                r_out_s2   <= sym;
                r_out_word <= 5'(r_held0) * 5'(sax_enc_pkg::ALPHABET * sax_enc_pkg::ALPHABET)
                            + 5'(r_held1) * 5'(sax_enc_pkg::ALPHABET) + 5'(sym);
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b00000, r_out_word, r_out_s2, r_out_s1, r_out_s0};

endmodule

// ----- rtl/core/sax_enc_chk.sv -----
// ---------------------------------------------------------------------------
// sax_enc_chk: port checker for the SAX word encoder
// Watches the word stream for consistent words and a well-behaved handshake.
// ---------------------------------------------------------------------------
module sax_enc_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [sax_enc_pkg::M_DATA_W-1:0]  o_m_tdata
);

    // No word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("word valid after reset");

    // Every symbol stays in the three-letter alphabet
    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] != 2'd3) && (o_m_tdata[3:2] != 2'd3)
                       && (o_m_tdata[5:4] != 2'd3))
        else $error("symbol out of range");

    // Word index matches its three symbols
    a_word_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[10:6] == 5'(o_m_tdata[1:0]) * 5'd9
                        + 5'(o_m_tdata[3:2]) * 5'd3 + 5'(o_m_tdata[5:4])))
        else $error("word index does not match symbols");

    // Hold a stalled word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled word changed");

endmodule

bind sax_word_encoder sax_enc_chk u_sax_enc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
